@@ hw/rtl/slot_pool_allocator_macros.svh @@
// Assertion macros shared by the slot pool allocator RTL.
`ifndef SLOT_POOL_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SPA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/spa_pkg.sv @@
// Package: types, constants and helpers for the slot pool allocator.
`default_nettype none
package spa_pkg;

    localparam int SLOTS  = 256;
    localparam int DATA_W = 32;
    localparam int ID_W   = 8;
    localparam int CNT_W  = 9;
    localparam int CELL_W = 16;
    localparam int SUB_W  = 4;
    localparam int NCELL  = SLOTS / CELL_W;
    localparam int BASE_W = ID_W - SUB_W;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEACT = 2'd1,
        CMD_GET   = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   slot_id;
        logic [DATA_W-1:0] entry_data;
        logic              entry_active;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic              ok;
        logic [DATA_W-1:0] data_out;
        logic              data_active;
        logic [CNT_W-1:0]  active_count;
    } t_out;

    // request token travelling down the cell row
    typedef struct packed {
        logic            valid;
        logic [1:0]      op;
        logic [ID_W-1:0] id;
        logic            found;
        logic [ID_W-1:0] idx;
        logic            act;
    } t_tok;

    // slot write broadcast to all cells
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] idx;
        logic            act;
    } t_wr;

    function automatic logic [SUB_W-1:0] first_set(input logic [CELL_W-1:0] v);
        logic [SUB_W-1:0] r;
        r = '0;
        for (int i = CELL_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = SUB_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/spa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/spa_cell.sv @@
// One cell of the slot row: active and used bits of a group of slots.
`default_nettype none
module spa_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [spa_pkg::BASE_W-1:0] i_base,
    input  wire spa_pkg::t_tok              i_tok,
    input  wire spa_pkg::t_wr               i_wr,
    output spa_pkg::t_tok                   o_tok
);

    logic [spa_pkg::CELL_W-1:0] r_act, n_act;
    logic [spa_pkg::CELL_W-1:0] r_used, n_used;
    spa_pkg::t_tok              r_tok, n_tok;
    logic [spa_pkg::CELL_W-1:0] free;
    logic [spa_pkg::SUB_W-1:0]  sub;
    logic [spa_pkg::SUB_W-1:0]  wsub;
    logic                       hit;
    logic                       whit;

    assign free = r_used & ~r_act;
    assign sub  = i_tok.id[spa_pkg::SUB_W-1:0];
    assign hit  = i_tok.id[spa_pkg::ID_W-1:spa_pkg::SUB_W] == i_base;
    assign wsub = i_wr.idx[spa_pkg::SUB_W-1:0];
    assign whit = i_wr.idx[spa_pkg::ID_W-1:spa_pkg::SUB_W] == i_base;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            case (i_tok.op)
                spa_pkg::CMD_ADD: begin
                    if (!i_tok.found && (|free)) begin
                        n_tok.found = 1'b1;
                        n_tok.idx   = {i_base, spa_pkg::first_set(free)};
                    end
                end
                spa_pkg::CMD_DEACT,
                spa_pkg::CMD_GET: begin
                    if (hit) begin
                        n_tok.act = r_act[sub];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_act  = r_act;
        n_used = r_used;
        if (i_tok.valid && (i_tok.op == spa_pkg::CMD_DEACT) && hit) begin
            n_act[sub] = 1'b0;
        end
        if (i_wr.en && whit) begin
            n_act[wsub]  = i_wr.act;
            n_used[wsub] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= '0;
            r_used <= '0;
            r_tok  <= '0;
        end else begin
            r_act  <= n_act;
            r_used <= n_used;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

@@ hw/rtl/slot_pool_allocator.sv @@
// Top level of the slot pool allocator: request control, cell row, payload RAM.
//
// Usage: drive a request beat on i_item and raise start; it is taken at a
// rising edge with start high and busy low. cmd selects add (store the entry
// in the lowest inactive handed-out slot, else the next fresh slot),
// deactivate (clear a slot's active bit) or get (read a slot back).
// Each request gives exactly one result beat on o_result, marked by o_strobe
// for one cycle; the receiver must take it then, there is no stall.
// Every result carries the active slot count after the request.
// The request token walks the 16-cell slot row at one cell per cycle,
// registered in each cell; the result is registered from the row end and
// busy stays high until then. A new request is taken only after busy falls.
// Payload words sit in a 256 x 32 RAM, written by add and read by get;
// never-written words are never returned.
// Reset (i_rst_n low, synchronous) clears all active and used bits, both
// counters and the control state; no clearing pass is needed.
`default_nettype none
`include "slot_pool_allocator_macros.svh"
module slot_pool_allocator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire spa_pkg::t_in  i_item,
    output logic               busy,
    output logic               o_strobe,
    output spa_pkg::t_out      o_result
);

    spa_pkg::t_state               r_state, n_state;
    spa_pkg::t_tok                 r_tok0, n_tok0;
    spa_pkg::t_in                  r_req;
    logic [spa_pkg::CNT_W-1:0]     r_used_cnt, n_used_cnt;
    logic [spa_pkg::CNT_W-1:0]     r_active_total, n_active_total;
    logic                          r_strobe, n_strobe;
    spa_pkg::t_out                 r_out, n_out;
    spa_pkg::t_tok                 tok [spa_pkg::NCELL+1];
    spa_pkg::t_tok                 tok_end;
    spa_pkg::t_wr                  wr;
    logic [spa_pkg::DATA_W-1:0]    ram_rdata;
    logic                          accept;
    logic                          fini;
    logic                          in_range;
    logic                          room;

    assign busy     = r_state != spa_pkg::ST_IDLE;
    assign accept   = start && !busy;
    assign tok[0]   = r_tok0;
    assign tok_end  = tok[spa_pkg::NCELL];
    assign fini     = (r_state == spa_pkg::ST_RUN) && tok_end.valid;
    assign in_range = {1'b0, r_req.slot_id} < r_used_cnt;
    assign room     = r_used_cnt < spa_pkg::CNT_W'(spa_pkg::SLOTS);

    for (genvar g = 0; g < spa_pkg::NCELL; g++) begin : g_cell
        spa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_base  (spa_pkg::BASE_W'(g)),
            .i_tok   (tok[g]),
            .i_wr    (wr),
            .o_tok   (tok[g+1])
        );
    end

    spa_ram #(
        .WIDTH (spa_pkg::DATA_W),
        .DEPTH (spa_pkg::SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.idx),
        .i_wdata (r_req.entry_data),
        .i_re    (accept),
        .i_raddr (i_item.slot_id),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            spa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = spa_pkg::ST_RUN;
                end
            end
            spa_pkg::ST_RUN: begin
                if (tok_end.valid) begin
                    n_state = spa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_tok0       = '0;
        n_tok0.valid = accept;
        n_tok0.op    = i_item.cmd;
        n_tok0.id    = i_item.slot_id;
    end

    always_comb begin
        n_used_cnt     = r_used_cnt;
        n_active_total = r_active_total;
        n_strobe       = 1'b0;
        n_out          = '0;
        wr             = '0;
        if (fini) begin
            n_strobe        = 1'b1;
            n_out.result_id = r_req.slot_id;
            case (r_req.cmd)
                spa_pkg::CMD_ADD: begin
                    n_out.result_id = '0;
                    if (tok_end.found) begin
                        wr.en = 1'b1;
                        wr.idx = tok_end.idx;
                    end else if (room) begin
                        wr.en = 1'b1;
                        wr.idx = r_used_cnt[spa_pkg::ID_W-1:0];
                        n_used_cnt = r_used_cnt + spa_pkg::CNT_W'(1);
                    end
                    if (wr.en) begin
                        wr.act          = r_req.entry_active;
                        n_out.ok        = 1'b1;
                        n_out.result_id = wr.idx;
                        n_active_total  = r_active_total
                                          + spa_pkg::CNT_W'(r_req.entry_active);
                    end
                end
                spa_pkg::CMD_DEACT: begin
                    n_out.ok       = in_range;
                    n_active_total = r_active_total - spa_pkg::CNT_W'(tok_end.act);
                end
                spa_pkg::CMD_GET: begin
                    n_out.ok = in_range;
                    if (in_range) begin
                        n_out.data_out    = ram_rdata;
                        n_out.data_active = tok_end.act;
                    end
                end
                default: begin
                end
            endcase
            n_out.active_count = n_active_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= spa_pkg::ST_IDLE;
            r_tok0         <= '0;
            r_used_cnt     <= '0;
            r_active_total <= '0;
            r_strobe       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_tok0         <= n_tok0;
            r_used_cnt     <= n_used_cnt;
            r_active_total <= n_active_total;
            r_strobe       <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_item;
        end
        if (fini) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    `SPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy && !o_strobe, "busy not raised after accept")
    `SPA_ASSERT_NEXT(a_fini_strobe, i_clk, i_rst_n, fini, o_strobe && !busy, "result not issued after row scan")
    `SPA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_active_total <= r_used_cnt, "active count exceeds used slots")
    `SPA_ASSERT_NOW(a_tok_idle, i_clk, i_rst_n, r_state == spa_pkg::ST_IDLE, !tok_end.valid, "token at row end while idle")

endmodule
`default_nettype wire
